### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, held off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/alu16_pkg.sv
// ---------------------------------------------------------------------------
// alu16_pkg
// Shared widths, opcodes, micro-op codes and beat types of the ALU.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alu16_pkg;

	localparam int unsigned DATA_WIDTH = 16;
	localparam int unsigned SHIFT_W    = $clog2(DATA_WIDTH);
	localparam int unsigned OPC_W      = 5;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [OPC_W-1:0]      opc_t;

	localparam opc_t OPC_ADD  = 5'd0;
	localparam opc_t OPC_SUB  = 5'd1;
	localparam opc_t OPC_LSR  = 5'd2;
	localparam opc_t OPC_LSL  = 5'd3;
	localparam opc_t OPC_LSL2 = 5'd4;
	localparam opc_t OPC_ASR  = 5'd5;
	localparam opc_t OPC_MOV  = 5'd6;
	localparam opc_t OPC_MUL  = 5'd7;
	localparam opc_t OPC_DIV  = 5'd8;
	localparam opc_t OPC_MOD  = 5'd9;
	localparam opc_t OPC_AND  = 5'd10;
	localparam opc_t OPC_OR   = 5'd11;
	localparam opc_t OPC_XOR  = 5'd12;
	localparam opc_t OPC_NOT  = 5'd13;
	localparam opc_t OPC_TST  = 5'd14;
	localparam opc_t OPC_CMP  = 5'd15;
	localparam opc_t OPC_INC  = 5'd16;
	localparam opc_t OPC_DEC  = 5'd17;

	typedef enum logic [4:0] {
		UOP_ADD,
		UOP_SUB,
		UOP_DIFF,
		UOP_LSR,
		UOP_LSL,
		UOP_ASR,
		UOP_MOV,
		UOP_MUL,
		UOP_DIV,
		UOP_MOD,
		UOP_AND,
		UOP_OR,
		UOP_XOR,
		UOP_NOT,
		UOP_INC,
		UOP_DEC,
		UOP_ZERO
	} uop_code_t;

	typedef struct packed {
		opc_t  req_type;
		data_t op_a;
		data_t op_b;
	} req_t;

	typedef struct packed {
		data_t alu_result;
		logic  zero_flag;
		logic  negative_flag;
		logic  carry_flag;
		logic  overflow_flag;
	} rsp_t;

	typedef struct packed {
		uop_code_t op;
		data_t     op_a;
		data_t     op_b;
	} uop_t;

endpackage

`default_nettype wire

### design/alu16_fifo.sv
// ---------------------------------------------------------------------------
// alu16_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alu16_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	output logic full,
	input  T     din,
	input  wire  pop,
	output logic empty,
	output T     dout
);

	localparam int AW = $clog2(DEPTH);

	T               mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;
	logic           wr_en;
	logic           rd_en;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

### design/alu16_front.sv
// ---------------------------------------------------------------------------
// alu16_front
// Accept request beats and decode the opcode into a micro-op.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alu16_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	output logic            full,
	input  alu16_pkg::req_t req,
	output logic            uop_push,
	input  wire             uop_full,
	output alu16_pkg::uop_t uop
);

	import alu16_pkg::*;

	logic      valid_s1;
	uop_t      uop_s1;
	uop_code_t code;
	logic      advance;

	always_comb begin
		case (req.req_type)
			OPC_ADD:            code = UOP_ADD;
			OPC_SUB:            code = UOP_SUB;
			OPC_LSR:            code = UOP_LSR;
			OPC_LSL, OPC_LSL2:  code = UOP_LSL;
			OPC_ASR:            code = UOP_ASR;
			OPC_MOV:            code = UOP_MOV;
			OPC_MUL:            code = UOP_MUL;
			OPC_DIV:            code = UOP_DIV;
			OPC_MOD:            code = UOP_MOD;
			OPC_AND:            code = UOP_AND;
			OPC_OR:             code = UOP_OR;
			OPC_XOR:            code = UOP_XOR;
			OPC_NOT:            code = UOP_NOT;
			OPC_TST, OPC_CMP:   code = UOP_DIFF;
			OPC_INC:            code = UOP_INC;
			OPC_DEC:            code = UOP_DEC;
			default:            code = UOP_ZERO;
		endcase
	end

	assign advance  = !valid_s1 || !uop_full;
	assign full     = !advance;
	assign uop_push = valid_s1;
	assign uop      = uop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			uop_s1.op   <= code;
			uop_s1.op_a <= req.op_a;
			uop_s1.op_b <= req.op_b;
		end
	end

endmodule

`default_nettype wire

### design/alu16_back.sv
// ---------------------------------------------------------------------------
// alu16_back
// Execute stage followed by a one-bit-per-stage restoring divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alu16_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             uop_empty,
	output logic            uop_pop,
	input  alu16_pkg::uop_t uop,
	output logic            rsp_push,
	input  wire             rsp_full,
	output alu16_pkg::rsp_t rsp
);

	import alu16_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int SW = SHIFT_W;

	typedef struct packed {
		logic  is_div;
		logic  is_mod;
		logic  div_zero;
		data_t res;
		logic  c;
		logic  v;
		data_t rem;
		data_t dq;
		data_t dvs;
	} stg_t;

	logic            advance;
	logic            exe_vld_s1;
	stg_t            exe_s1;
	stg_t            exe_d;
	logic [DW-1:0]   div_vld_s;
	stg_t            div_s [DW];
	stg_t            prv [DW];
	stg_t            nxt [DW];

	logic [DW:0]     sum;
	logic [DW:0]     diff;
	logic [2*DW-1:0] prod;
	logic            big;
	logic [SW-1:0]   sh;
	logic            sa;
	logic            sb;
	stg_t            last;
	data_t           fin;

	assign advance = !div_vld_s[DW-1] || !rsp_full;
	assign uop_pop = advance && !uop_empty;

	always_comb begin
		sum  = {1'b0, uop.op_a} + {1'b0, uop.op_b};
		diff = {1'b0, uop.op_a} - {1'b0, uop.op_b};
		prod = {{DW{1'b0}}, uop.op_a} * {{DW{1'b0}}, uop.op_b};
		big  = (uop.op_b >= data_t'(DATA_WIDTH));
		sh   = uop.op_b[SW-1:0];
		sa   = uop.op_a[DW-1];
		sb   = uop.op_b[DW-1];

		exe_d          = '0;
		exe_d.dq       = uop.op_a;
		exe_d.dvs      = uop.op_b;
		exe_d.div_zero = (uop.op_b == '0);

		case (uop.op)
			UOP_ADD: begin
				exe_d.res = sum[DW-1:0];
				exe_d.c   = sum[DW];
				exe_d.v   = (sa == sb) && (sum[DW-1] != sa);
			end
			UOP_SUB: begin
				exe_d.res = diff[DW-1:0];
				exe_d.c   = diff[DW];
				exe_d.v   = (sa != sb) && (diff[DW-1] != sa);
			end
			UOP_DIFF: exe_d.res = diff[DW-1:0];
			UOP_LSR: begin
				exe_d.res = big ? '0 : (uop.op_a >> sh);
				exe_d.c   = uop.op_a[0];
			end
			UOP_LSL:  exe_d.res = big ? '0 : (uop.op_a << sh);
			UOP_ASR: begin
				exe_d.res = big ? {DW{sa}} : data_t'($signed(uop.op_a) >>> sh);
				exe_d.c   = uop.op_a[0];
			end
			UOP_MOV:  exe_d.res = uop.op_b;
			UOP_MUL:  exe_d.res = prod[DW-1:0];
			UOP_DIV:  exe_d.is_div = 1'b1;
			UOP_MOD: begin
				exe_d.is_div = 1'b1;
				exe_d.is_mod = 1'b1;
			end
			UOP_AND:  exe_d.res = uop.op_a & uop.op_b;
			UOP_OR:   exe_d.res = uop.op_a | uop.op_b;
			UOP_XOR:  exe_d.res = uop.op_a ^ uop.op_b;
			UOP_NOT:  exe_d.res = ~uop.op_a;
			UOP_INC:  exe_d.res = uop.op_a + data_t'(1);
			UOP_DEC:  exe_d.res = uop.op_a - data_t'(1);
			default:  exe_d.res = '0;
		endcase
	end

	always_comb begin
		prv[0] = exe_s1;
		for (int k = 1; k < DW; k++) begin
			prv[k] = div_s[k-1];
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [DW:0] trial;
		logic        ge;
		always_comb begin
			trial  = {prv[k].rem, prv[k].dq[DW-1]};
			ge     = (trial >= {1'b0, prv[k].dvs});
			nxt[k] = prv[k];
			if (ge) begin
				nxt[k].rem = DW'(trial - {1'b0, prv[k].dvs});
			end else begin
				nxt[k].rem = trial[DW-1:0];
			end
			nxt[k].dq = {prv[k].dq[DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exe_vld_s1 <= 1'b0;
			div_vld_s  <= '0;
		end else if (advance) begin
			exe_vld_s1 <= !uop_empty;
			div_vld_s  <= {div_vld_s[DW-2:0], exe_vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			exe_s1 <= exe_d;
			for (int k = 0; k < DW; k++) begin
				div_s[k] <= nxt[k];
			end
		end
	end

	always_comb begin
		last = div_s[DW-1];
		if (!last.is_div) begin
			fin = last.res;
		end else if (last.div_zero) begin
			fin = '1;
		end else if (last.is_mod) begin
			fin = last.rem;
		end else begin
			fin = last.dq;
		end
		rsp.alu_result    = fin;
		rsp.zero_flag     = (fin == '0);
		rsp.negative_flag = fin[DW-1];
		rsp.carry_flag    = last.c;
		rsp.overflow_flag = last.v;
	end

	assign rsp_push = div_vld_s[DW-1];

endmodule

`default_nettype wire

### design/alu16_with_flags.sv
// ---------------------------------------------------------------------------
// alu16_with_flags
// 16-bit ALU with zero, negative, carry and overflow flags.
// ---------------------------------------------------------------------------
// Takes one request beat per cycle and returns one result beat per request,
// in order. A request passes a decode register, a MID_DEPTH-entry queue, one
// execute stage and a 16-stage divider pipeline (one quotient bit per stage)
// that every operation walks through on its way to the result side.
// Sustained rate is one beat per cycle; the back pipeline halts as a whole
// only while the OUT_DEPTH-entry result queue is full, and the front keeps
// taking beats until the middle queue also fills.
`timescale 1ns / 1ps
`default_nettype none

module alu16_with_flags #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	output logic            full,
	input  alu16_pkg::req_t req,
	output logic            empty,
	input  wire             pop,
	output alu16_pkg::rsp_t rsp
);

	import alu16_pkg::*;

	logic uop_push;
	logic uop_full;
	uop_t uop_in;
	logic uop_empty;
	logic uop_pop;
	uop_t uop_out;
	logic rsp_push;
	logic rsp_full;
	rsp_t rsp_in;

	alu16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.uop_push (uop_push),
		.uop_full (uop_full),
		.uop      (uop_in)
	);

	alu16_fifo #(
		.T     (uop_t),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (uop_push),
		.full   (uop_full),
		.din    (uop_in),
		.pop    (uop_pop),
		.empty  (uop_empty),
		.dout   (uop_out)
	);

	alu16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop_empty (uop_empty),
		.uop_pop   (uop_pop),
		.uop       (uop_out),
		.rsp_push  (rsp_push),
		.rsp_full  (rsp_full),
		.rsp       (rsp_in)
	);

	alu16_fifo #(
		.T     (rsp_t),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_push),
		.full   (rsp_full),
		.din    (rsp_in),
		.pop    (pop),
		.empty  (empty),
		.dout   (rsp)
	);

endmodule

`default_nettype wire

### design/alu16_checker.sv
// ---------------------------------------------------------------------------
// alu16_checker
// Port-level checks on result beats, bound to the ALU top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module alu16_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             empty,
	input wire             pop,
	input alu16_pkg::rsp_t rsp
);

	import alu16_pkg::*;

	`ASSERT_IMPL(a_zero_flag, !empty, rsp.zero_flag == (rsp.alu_result == '0), "zero flag")
	`ASSERT_IMPL(a_neg_flag, !empty, rsp.negative_flag == rsp.alu_result[DATA_WIDTH-1], "neg flag")
	`ASSERT_IMPL(a_neg_nonzero, !empty && rsp.negative_flag, !rsp.zero_flag, "neg and zero")
	`ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp), "stalled result beat changed")

endmodule

bind alu16_with_flags alu16_checker u_chk (.*);

`default_nettype wire

### tb/sv/alu16_with_flags_tb.sv
// ---------------------------------------------------------------------------
// alu16_with_flags_tb
// Self-checking bench for the 16-bit flag ALU behind its queue handshakes.
// ---------------------------------------------------------------------------
// Request beats carry opcodes, operand corners and random data. A scoreboard
// computes the result and flags of every accepted request and compares each
// popped result beat, in order, field by field. Push and pop idle at random
// in two mixes and never idle in a third. A long pop hold backs the block up
// into its input, and full drains sit between the phases.
`timescale 1ns / 1ps

import alu16_pkg::*;

class alu_scoreboard;

	typedef struct packed {
		req_t cmd;
		rsp_t want;
	} pending_t;

	pending_t pending[$];
	int       noted       = 0;
	int       checked     = 0;
	int       mismatches  = 0;
	int       print_limit = 40;

	function int pending_count();
		return pending.size();
	endfunction

	function rsp_t predict(req_t q);
		logic [DATA_WIDTH:0] wide;
		data_t               a;
		data_t               b;
		data_t               r;
		logic                c;
		logic                v;
		rsp_t                p;
		a = q.op_a;
		b = q.op_b;
		r = '0;
		c = 1'b0;
		v = 1'b0;
		case (q.req_type)
			OPC_ADD: begin
				wide = {1'b0, a} + {1'b0, b};
				r    = wide[DATA_WIDTH-1:0];
				c    = wide[DATA_WIDTH];
				v    = (a[DATA_WIDTH-1] == b[DATA_WIDTH-1]) &&
				       (r[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
			end
			OPC_SUB: begin
				r = a - b;
				c = (a < b);
				v = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) &&
				    (r[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
			end
			OPC_LSR: begin
				r = (b >= DATA_WIDTH) ? '0 : (a >> b);
				c = a[0];
			end
			OPC_LSL, OPC_LSL2: begin
				r = (b >= DATA_WIDTH) ? '0 : (a << b);
			end
			OPC_ASR: begin
				r = (b >= DATA_WIDTH) ? {DATA_WIDTH{a[DATA_WIDTH-1]}} :
				    data_t'($signed(a) >>> b);
				c = a[0];
			end
			OPC_MOV: r = b;
			OPC_MUL: r = a * b;
			OPC_DIV: r = (b == '0) ? '1 : (a / b);
			OPC_MOD: r = (b == '0) ? '1 : (a % b);
			OPC_AND: r = a & b;
			OPC_OR:  r = a | b;
			OPC_XOR: r = a ^ b;
			OPC_NOT: r = ~a;
			OPC_TST, OPC_CMP: r = a - b;
			OPC_INC: r = a + 1'b1;
			OPC_DEC: r = a - 1'b1;
			default: r = '0;
		endcase
		p.alu_result    = r;
		p.zero_flag     = (r == '0);
		p.negative_flag = r[DATA_WIDTH-1];
		p.carry_flag    = c;
		p.overflow_flag = v;
		return p;
	endfunction

	function void note_request(req_t q);
		pending_t e;
		e.cmd  = q;
		e.want = predict(q);
		pending.push_back(e);
		noted++;
	endfunction

	task report(string msg);
		if (mismatches < print_limit) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	task check_result(rsp_t got);
		pending_t e;
		string    ctx;
		if (pending.size() == 0) begin
			report($sformatf("result beat %h with no request pending", got));
		end else begin
			e = pending.pop_front();
			checked++;
			ctx = $sformatf("op %0d a %h b %h", e.cmd.req_type, e.cmd.op_a, e.cmd.op_b);
			if (got.alu_result !== e.want.alu_result)
				report($sformatf("%s: result %h, want %h", ctx, got.alu_result,
				       e.want.alu_result));
			if (got.zero_flag !== e.want.zero_flag)
				report($sformatf("%s: zero %b, want %b", ctx, got.zero_flag,
				       e.want.zero_flag));
			if (got.negative_flag !== e.want.negative_flag)
				report($sformatf("%s: negative %b, want %b", ctx, got.negative_flag,
				       e.want.negative_flag));
			if (got.carry_flag !== e.want.carry_flag)
				report($sformatf("%s: carry %b, want %b", ctx, got.carry_flag,
				       e.want.carry_flag));
			if (got.overflow_flag !== e.want.overflow_flag)
				report($sformatf("%s: overflow %b, want %b", ctx, got.overflow_flag,
				       e.want.overflow_flag));
		end
	endtask

endclass

module alu16_with_flags_tb;

	localparam int   CLK_PERIOD     = 20;
	localparam int   RESET_CYCLES   = 11;
	localparam int   PHASE_ITEMS    = 660;
	localparam int   LONG_HOLD      = 150;
	localparam int   SETTLE_CYCLES  = 25;
	localparam int   WATCHDOG_LIMIT = 5000;
	localparam opc_t OPC_UNUSED_LO  = 5'd18;
	localparam opc_t OPC_UNUSED_HI  = 5'd31;

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  push   = 1'b0;
	logic  full;
	req_t  req    = '0;
	logic  empty;
	logic  pop    = 1'b0;
	rsp_t  rsp;

	alu_scoreboard sb;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            result_hold   = 0;
	int            quiet_cycles  = 0;

	alu16_with_flags dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				sb.check_result(rsp);
			if (result_hold > 0) begin
				pop <= 1'b0;
				result_hold = result_hold - 1;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic data_t pick_operand();
		int sel;
		sel = $urandom_range(99);
		if (sel < 25) begin
			case ($urandom_range(4))
				0:       return 16'h0000;
				1:       return 16'h0001;
				2:       return 16'h7FFF;
				3:       return 16'h8000;
				default: return 16'hFFFF;
			endcase
		end
		if (sel < 40)
			return data_t'($urandom_range(15));
		return data_t'($urandom_range(16'hFFFF));
	endfunction

	function automatic req_t random_request();
		req_t q;
		if ($urandom_range(99) < 8)
			q.req_type = opc_t'($urandom_range(OPC_UNUSED_HI, OPC_UNUSED_LO));
		else
			q.req_type = opc_t'($urandom_range(OPC_DEC, OPC_ADD));
		q.op_a = pick_operand();
		q.op_b = pick_operand();
		case (q.req_type)
			OPC_LSR, OPC_LSL, OPC_LSL2, OPC_ASR: begin
				if ($urandom_range(99) < 70)
					q.op_b = data_t'($urandom_range(20));
			end
			OPC_DIV, OPC_MOD: begin
				if ($urandom_range(99) < 10)
					q.op_b = '0;
			end
			default: ;
		endcase
		return q;
	endfunction

	task automatic send_request(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req  <= item;
		do begin
			@(posedge clk);
		end while (full);
		sb.note_request(item);
	endtask

	task automatic wait_results_drained();
		push <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(req_t'{OPC_ADD,  16'hFFFF, 16'h0001});
		send_request(req_t'{OPC_ADD,  16'h7FFF, 16'h0001});
		send_request(req_t'{OPC_ADD,  16'h8000, 16'h8000});
		send_request(req_t'{OPC_SUB,  16'h0000, 16'h0001});
		send_request(req_t'{OPC_SUB,  16'h8000, 16'h0001});
		send_request(req_t'{OPC_SUB,  16'h7FFF, 16'hFFFF});
		send_request(req_t'{OPC_LSR,  16'h8001, 16'h0001});
		send_request(req_t'{OPC_LSR,  16'hFFFF, 16'h0010});
		send_request(req_t'{OPC_LSL,  16'hFFFF, 16'h000F});
		send_request(req_t'{OPC_LSL2, 16'h0001, 16'hFFFF});
		send_request(req_t'{OPC_ASR,  16'h8000, 16'h000F});
		send_request(req_t'{OPC_ASR,  16'h8001, 16'h0010});
		send_request(req_t'{OPC_ASR,  16'h7FFF, 16'hFFFF});
		send_request(req_t'{OPC_MOV,  16'h0000, 16'hFFFF});
		send_request(req_t'{OPC_MUL,  16'hFFFF, 16'hFFFF});
		send_request(req_t'{OPC_DIV,  16'hFFFF, 16'h0000});
		send_request(req_t'{OPC_MOD,  16'h1234, 16'h0000});
		send_request(req_t'{OPC_MOD,  16'h0064, 16'h0007});
		send_request(req_t'{OPC_AND,  16'hF0F0, 16'hFF00});
		send_request(req_t'{OPC_OR,   16'h0000, 16'h0000});
		send_request(req_t'{OPC_XOR,  16'hFFFF, 16'hFFFF});
		send_request(req_t'{OPC_NOT,  16'h0000, 16'h1234});
		send_request(req_t'{OPC_TST,  16'h0000, 16'h0001});
		send_request(req_t'{OPC_CMP,  16'h8000, 16'h8000});
		send_request(req_t'{OPC_INC,  16'hFFFF, 16'h0000});
		send_request(req_t'{OPC_DEC,  16'h0000, 16'h0000});
		send_request(req_t'{OPC_UNUSED_LO, 16'h1234, 16'h5678});
		send_request(req_t'{OPC_UNUSED_HI, 16'hFFFF, 16'hFFFF});
		wait_results_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold pop while pushes continue, or pause pushes until empty
				if (i == PHASE_ITEMS / 2) begin
					if (phase == 1)
						wait_results_drained();
					else
						result_hold = LONG_HOLD;
				end
				send_request(random_request());
			end
			wait_results_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d request beats: all opcodes, unused codes, shift, divide and flag corners",
		         sb.noted);
		$display("under three idle mixes, a long pop hold and drains; %0d checked, %0d mismatches",
		         sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_count() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
